@@ src/abeu_pkg.sv @@
// Package for the ALU and branch execute unit.
// Holds instruction class and opcode codes, the controller state type and the
// command and status structs. No dependencies.
package abeu_pkg;

	localparam int unsigned ACT_W  = 2;
	localparam int unsigned OP_W   = 5;
	localparam int unsigned IMM_W  = 22;
	localparam int unsigned OFF_W  = 26;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned FLAG_W = 3;

	localparam logic [ACT_W-1:0] ACT_ALU    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_BRANCH = 2'd1;
	localparam logic [ACT_W-1:0] ACT_MISC   = 2'd2;

	localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
	localparam logic [OP_W-1:0] OP_SUB  = 5'd1;
	localparam logic [OP_W-1:0] OP_DIV  = 5'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 5'd3;
	localparam logic [OP_W-1:0] OP_MOD  = 5'd4;
	localparam logic [OP_W-1:0] OP_ASR  = 5'd5;
	localparam logic [OP_W-1:0] OP_ASL  = 5'd7;
	localparam logic [OP_W-1:0] OP_LSR  = 5'd8;
	localparam logic [OP_W-1:0] OP_LSL  = 5'd9;
	localparam logic [OP_W-1:0] OP_AND  = 5'd10;
	localparam logic [OP_W-1:0] OP_OR   = 5'd11;
	localparam logic [OP_W-1:0] OP_XOR  = 5'd12;
	localparam logic [OP_W-1:0] OP_ADDI = 5'd16;
	localparam logic [OP_W-1:0] OP_SUBI = 5'd17;
	localparam logic [OP_W-1:0] OP_MULI = 5'd18;
	localparam logic [OP_W-1:0] OP_ASRI = 5'd19;
	localparam logic [OP_W-1:0] OP_ASLI = 5'd20;
	localparam logic [OP_W-1:0] OP_ANDI = 5'd21;
	localparam logic [OP_W-1:0] OP_ORI  = 5'd22;
	localparam logic [OP_W-1:0] OP_XORI = 5'd23;
	localparam logic [OP_W-1:0] OP_DIVI = 5'd24;
	localparam logic [OP_W-1:0] OP_MODI = 5'd25;
	localparam logic [OP_W-1:0] OP_LSRI = 5'd26;
	localparam logic [OP_W-1:0] OP_LSLI = 5'd27;
	localparam logic [OP_W-1:0] OP_CMP  = 5'd28;
	localparam logic [OP_W-1:0] OP_CMPI = 5'd31;

	localparam logic [OP_W-1:0] BR_B   = 5'd0;
	localparam logic [OP_W-1:0] BR_BEQ = 5'd1;
	localparam logic [OP_W-1:0] BR_BNE = 5'd2;
	localparam logic [OP_W-1:0] BR_BLT = 5'd3;
	localparam logic [OP_W-1:0] BR_BLE = 5'd4;
	localparam logic [OP_W-1:0] BR_BGT = 5'd5;
	localparam logic [OP_W-1:0] BR_BGE = 5'd6;
	localparam logic [OP_W-1:0] BR_BL  = 5'd7;
	localparam logic [OP_W-1:0] BR_BX  = 5'd8;

	localparam logic [OP_W-1:0] MS_NOT  = 5'd0;
	localparam logic [OP_W-1:0] MS_LD   = 5'd1;
	localparam logic [OP_W-1:0] MS_STR  = 5'd2;
	localparam logic [OP_W-1:0] MS_LDB  = 5'd6;
	localparam logic [OP_W-1:0] MS_STRB = 5'd7;
	localparam logic [OP_W-1:0] MS_LDI  = 5'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} abeu_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input item and evaluate it
		logic div_step;  // one restoring divide step
		logic finish;    // write the output register
	} abeu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic needs_div; // captured item is a real DIV or MOD
		logic div_last;  // final divide step is under way
	} abeu_stat_t;

endpackage

@@ src/abeu_in_if.sv @@
// Input channel interface of the ALU and branch execute unit.
// Depends on abeu_pkg for field widths.
interface abeu_in_if;
	import abeu_pkg::*;
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [OP_W-1:0]   opcode;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic [IMM_W-1:0]  immediate;
	logic [ADDR_W-1:0] instr_address;
	logic [OFF_W-1:0]  pc_offset;
	logic [ADDR_W-1:0] seq_pc;
	modport source (output valid, action, opcode, operand_a, operand_b, immediate,
		instr_address, pc_offset, seq_pc, input ready);
	modport sink (input valid, action, opcode, operand_a, operand_b, immediate,
		instr_address, pc_offset, seq_pc, output ready);
endinterface

@@ src/abeu_out_if.sv @@
// Output channel interface of the ALU and branch execute unit.
// Depends on abeu_pkg for field widths.
interface abeu_out_if;
	import abeu_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [31:0] result;
	logic [FLAG_W-1:0]  flags;
	logic [ADDR_W-1:0]  next_pc;
	logic               squash;
	logic [ADDR_W-1:0]  link_value;
	logic               link_write;
	modport source (output valid, result, flags, next_pc, squash, link_value, link_write,
		input ready);
	modport sink (input valid, result, flags, next_pc, squash, link_value, link_write,
		output ready);
endinterface

@@ src/alu_branch_execute_unit.sv @@
// Top level of the ALU and branch execute unit: joins the controller and the
// datapath to the input and output channel interfaces.
// Depends on abeu_pkg, abeu_in_if, abeu_out_if, abeu_ctrl and abeu_dp.
//
// Usage: one decoded instruction is transferred on the input channel and one
// result item comes back on the output channel for each. The unit holds one
// instruction at a time and accepts a new one only when the controller is idle.
// Each item passes through the controller states idle, divide and done before
// the output register is written; signed DIV and MOD with a divisor other than
// zero and minus one stay in the divide state for DATA_WIDTH steps of the
// radix-2 divider, and all other operations leave it without a divide step.
// The stored N, Z, V flags are cleared by reset; reset also empties the
// output register and returns the controller to idle.
// A stall on the output holds the result in the output register; the next
// instruction can still be taken and waits in done until the result drains.
module alu_branch_execute_unit #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	abeu_in_if.sink   in_ch,
	abeu_out_if.source out_ch
);
	import abeu_pkg::*;

	abeu_cmd_t  cmd;
	abeu_stat_t stat;

	abeu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	abeu_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (in_ch.action),
		.opcode        (in_ch.opcode),
		.operand_a     (in_ch.operand_a),
		.operand_b     (in_ch.operand_b),
		.immediate     (in_ch.immediate),
		.instr_address (in_ch.instr_address),
		.pc_offset     (in_ch.pc_offset),
		.seq_pc        (in_ch.seq_pc),
		.result        (out_ch.result),
		.flags         (out_ch.flags),
		.next_pc       (out_ch.next_pc),
		.squash        (out_ch.squash),
		.link_value    (out_ch.link_value),
		.link_write    (out_ch.link_write)
	);

endmodule

@@ src/abeu_ctrl.sv @@
// Controller state machine of the ALU and branch execute unit.
// Depends on abeu_pkg for the state, command and status types.
module abeu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  abeu_pkg::abeu_stat_t stat,
	output abeu_pkg::abeu_cmd_t  cmd
);
	import abeu_pkg::*;

	abeu_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIV;
			ST_DIV: begin
				if (!stat.needs_div || stat.div_last) state_d = ST_DONE;
			end
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV:  cmd.div_step = stat.needs_div;
			ST_DONE: cmd.finish = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/abeu_dp.sv @@
// Datapath of the ALU and branch execute unit: operand registers, the
// single-cycle ALU, branch resolution, a radix-2 divider and the output
// register. Depends on abeu_pkg.
module abeu_dp #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  abeu_pkg::abeu_cmd_t          cmd,
	output abeu_pkg::abeu_stat_t         stat,
	input  logic [abeu_pkg::ACT_W-1:0]   action,
	input  logic [abeu_pkg::OP_W-1:0]    opcode,
	input  logic signed [31:0]           operand_a,
	input  logic signed [31:0]           operand_b,
	input  logic [abeu_pkg::IMM_W-1:0]   immediate,
	input  logic [abeu_pkg::ADDR_W-1:0]  instr_address,
	input  logic [abeu_pkg::OFF_W-1:0]   pc_offset,
	input  logic [abeu_pkg::ADDR_W-1:0]  seq_pc,
	output logic signed [31:0]           result,
	output logic [abeu_pkg::FLAG_W-1:0]  flags,
	output logic [abeu_pkg::ADDR_W-1:0]  next_pc,
	output logic                         squash,
	output logic [abeu_pkg::ADDR_W-1:0]  link_value,
	output logic                         link_write
);
	import abeu_pkg::*;

	localparam int unsigned DW  = DATA_WIDTH;
	localparam int unsigned CW  = $clog2(DW);
	localparam logic [CW-1:0] LAST = CW'(DW - 1);

	// Operands taken into the data width, sign-extended or truncated from 32 bits.
	logic [DW-1:0] a_in, b_in;
	assign a_in = DW'($signed(operand_a));
	assign b_in = DW'($signed(operand_b));

	logic [4:0]    sh;
	logic [DW-1:0] diff, alu_r, misc_r;
	logic [DW-1:0] prod;
	logic          is_cmp, b_zero, b_m1, is_div_op, is_mod_op;

	assign sh        = b_in[4:0];
	assign diff      = a_in - b_in;
	assign prod      = a_in * b_in;
	assign is_cmp    = (opcode == OP_CMP) || (opcode == OP_CMPI);
	assign b_zero    = (b_in == '0);
	assign b_m1      = (b_in == '1);
	assign is_div_op = (opcode == OP_DIV) || (opcode == OP_DIVI);
	assign is_mod_op = (opcode == OP_MOD) || (opcode == OP_MODI);

	always_comb begin
		unique case (opcode)
			OP_ADD, OP_ADDI: alu_r = a_in + b_in;
			OP_SUB, OP_SUBI, OP_CMP, OP_CMPI: alu_r = diff;
			OP_MUL, OP_MULI: alu_r = prod;
			OP_DIV, OP_DIVI: alu_r = b_zero ? '1 : (-a_in);
			OP_MOD, OP_MODI: alu_r = b_zero ? a_in : '0;
			OP_ASR, OP_ASRI: alu_r = DW'($signed(a_in) >>> sh);
			OP_ASL, OP_LSL, OP_ASLI, OP_LSLI: alu_r = a_in << sh;
			OP_LSR, OP_LSRI: alu_r = a_in >> sh;
			OP_AND, OP_ANDI: alu_r = a_in & b_in;
			OP_OR, OP_ORI:   alu_r = a_in | b_in;
			OP_XOR, OP_XORI: alu_r = a_in ^ b_in;
			default: alu_r = '0;
		endcase
	end

	always_comb begin
		unique case (opcode)
			MS_NOT:          misc_r = ~a_in;
			MS_LD, MS_STR:   misc_r = a_in;
			MS_LDB, MS_STRB: misc_r = a_in + DW'({{(64 - IMM_W){1'b0}}, immediate});
			MS_LDI:          misc_r = DW'({{(64 - IMM_W){1'b0}}, immediate});
			default:         misc_r = '0;
		endcase
	end

	// Stored condition flags: bit 2 V, bit 1 Z, bit 0 N.
	logic [FLAG_W-1:0] flags_q, flags_new;
	assign flags_new = {($signed(diff) > $signed(a_in)), (diff == '0), diff[DW-1]};

	logic [ADDR_W-1:0] target, fall, npc;
	logic              take;
	assign target = instr_address + ADDR_W'(pc_offset);
	assign fall   = instr_address + ADDR_W'(1);

	always_comb begin
		unique case (opcode)
			BR_B:    take = 1'b1;
			BR_BEQ:  take = flags_q[1];
			BR_BNE:  take = !flags_q[1];
			BR_BLT:  take = flags_q[0];
			BR_BLE:  take = flags_q[0] || flags_q[1];
			BR_BGT:  take = !flags_q[0] && !flags_q[1];
			BR_BGE:  take = !flags_q[0] || flags_q[1];
			default: take = 1'b0;
		endcase
		if (opcode == BR_BX) npc = operand_a;
		else if (opcode == BR_BL || take) npc = target;
		else npc = seq_pc;
	end

	// Result of the single-cycle evaluation, held until the output register.
	logic [DW-1:0]     res_q;
	logic [ADDR_W-1:0] npc_q, link_q;
	logic              sq_q, lw_q, div_q, divmod_q, neg_q, aneg_q;

	// Restoring divider on magnitudes, one quotient bit per cycle.
	logic [DW-1:0] quo_q, rem_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;
	logic [DW-1:0] rem_sh;
	assign rem_sh = {rem_q[DW-2:0], quo_q[DW-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			div_q   <= 1'b0;
		end else if (cmd.load) begin
			div_q <= 1'b0;
			if (action == ACT_ALU) begin
				if (is_cmp) flags_q <= flags_new;
				div_q <= (is_div_op || is_mod_op) && !b_zero && !b_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q    <= '0;
			npc_q    <= '0;
			sq_q     <= 1'b0;
			link_q   <= '0;
			lw_q     <= 1'b0;
			divmod_q <= is_mod_op;
			neg_q    <= a_in[DW-1] ^ b_in[DW-1];
			aneg_q   <= a_in[DW-1];
			quo_q    <= a_in[DW-1] ? (-a_in) : a_in;
			dvs_q    <= b_in[DW-1] ? (-b_in) : b_in;
			rem_q    <= '0;
			cnt_q    <= '0;
			unique case (action)
				ACT_ALU:  res_q <= is_cmp ? '0 : alu_r;
				ACT_MISC: res_q <= misc_r;
				ACT_BRANCH: begin
					npc_q  <= npc;
					sq_q   <= (npc != fall);
					link_q <= (opcode == BR_BL) ? (seq_pc + ADDR_W'(1)) : '0;
					lw_q   <= (opcode == BR_BL);
				end
				default: ;
			endcase
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CW'(1);
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign stat.needs_div = div_q;
	assign stat.div_last  = (cnt_q == LAST);

	// Sign fix-up of the divider outputs: quotient sign from both operands,
	// remainder sign from the dividend.
	logic [DW-1:0] div_res;
	always_comb begin
		if (divmod_q) div_res = aneg_q ? (-rem_q) : rem_q;
		else div_res = neg_q ? (-quo_q) : quo_q;
	end

	logic [DW-1:0] final_res;
	assign final_res = div_q ? div_res : res_q;

	logic signed [31:0] result_q;
	logic [FLAG_W-1:0]  flags_o_q;
	logic [ADDR_W-1:0]  npc_o_q, link_o_q;
	logic               sq_o_q, lw_o_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q  <= 32'($signed(final_res));
			flags_o_q <= flags_q;
			npc_o_q   <= npc_q;
			sq_o_q    <= sq_q;
			link_o_q  <= link_q;
			lw_o_q    <= lw_q;
		end
	end

	assign result     = result_q;
	assign flags      = flags_o_q;
	assign next_pc    = npc_o_q;
	assign squash     = sq_o_q;
	assign link_value = link_o_q;
	assign link_write = lw_o_q;

endmodule

@@ dv/abeu_tb_pkg.sv @@
// Item types shared by the testbench of the ALU and branch execute unit.
// Depends on abeu_pkg for field widths and codes.
package abeu_tb_pkg;
	import abeu_pkg::*;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [OP_W-1:0]   opcode;
		logic [31:0]       operand_a;
		logic [31:0]       operand_b;
		logic [IMM_W-1:0]  immediate;
		logic [ADDR_W-1:0] instr_address;
		logic [OFF_W-1:0]  pc_offset;
		logic [ADDR_W-1:0] seq_pc;
	} instr_t;

	typedef struct packed {
		logic [31:0]       result;
		logic [FLAG_W-1:0] flags;
		logic [ADDR_W-1:0] next_pc;
		logic              squash;
		logic [ADDR_W-1:0] link_value;
		logic              link_write;
	} exec_out_t;

endpackage

@@ dv/abeu_tb_ifs.sv @@
// Timing constants of the testbench: reset length and the watchdog limit.
// No dependencies.
package abeu_tb_timing_pkg;
	localparam int unsigned RESET_CYCLES = 10;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
endpackage

@@ dv/alu_branch_execute_unit_tb.sv @@
// Self-checking testbench of the ALU and branch execute unit: directed and
// random instructions, a flag-tracking predictor and an in-order scoreboard.
// Depends on abeu_pkg, abeu_tb_pkg, abeu_tb_timing_pkg and the RTL.
module alu_branch_execute_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import abeu_pkg::*;
	import abeu_tb_pkg::*;
	import abeu_tb_timing_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	abeu_in_if  in_ch();
	abeu_out_if out_ch();

	alu_branch_execute_unit #(.DATA_WIDTH(32)) DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	instr_t    pending_instrs[$];
	exec_out_t expected_outs[$];
	logic [2:0] model_flags = '0;
	int unsigned errors = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_off_cycles = 0;
	int unsigned quiet_cycles = 0;

	function automatic void add_pending(instr_t t);
		pending_instrs = {pending_instrs, t};
	endfunction

	function automatic logic [31:0] alu_calc(logic [4:0] op, logic [31:0] a, logic [31:0] b);
		logic [4:0] sh;
		logic [63:0] prod;
		sh = b[4:0];
		prod = a * b;
		case (op)
			OP_ADD, OP_ADDI: return a + b;
			OP_SUB, OP_SUBI, OP_CMP, OP_CMPI: return a - b;
			OP_MUL, OP_MULI: return prod[31:0];
			OP_DIV, OP_DIVI: begin
				if (b == 0) return 32'hFFFF_FFFF;
				if (b == 32'hFFFF_FFFF) return 32'd0 - a;
				return $signed(a) / $signed(b);
			end
			OP_MOD, OP_MODI: begin
				if (b == 0) return a;
				if (b == 32'hFFFF_FFFF) return 32'd0;
				return $signed(a) % $signed(b);
			end
			OP_ASR, OP_ASRI: return $signed(a) >>> sh;
			OP_ASL, OP_LSL, OP_ASLI, OP_LSLI: return a << sh;
			OP_LSR, OP_LSRI: return a >> sh;
			OP_AND, OP_ANDI: return a & b;
			OP_OR, OP_ORI: return a | b;
			OP_XOR, OP_XORI: return a ^ b;
			default: return 32'd0;
		endcase
	endfunction

	// Works out the result of one instruction and advances the stored flags.
	function automatic exec_out_t execute_instr(instr_t t);
		exec_out_t o;
		logic [31:0] r;
		logic n, z, take;
		o = '0;
		n = model_flags[0];
		z = model_flags[1];
		take = 1'b0;
		if (t.action == ACT_ALU) begin
			r = alu_calc(t.opcode, t.operand_a, t.operand_b);
			if (t.opcode == OP_CMP || t.opcode == OP_CMPI)
				model_flags = {$signed(r) > $signed(t.operand_a), r == 0, r[31]};
			else
				o.result = r;
		end else if (t.action == ACT_MISC) begin
			case (t.opcode)
				MS_NOT: o.result = ~t.operand_a;
				MS_LD, MS_STR: o.result = t.operand_a;
				MS_LDB, MS_STRB: o.result = t.operand_a + 32'(t.immediate);
				MS_LDI: o.result = 32'(t.immediate);
				default: o.result = '0;
			endcase
		end else if (t.action == ACT_BRANCH) begin
			if (t.opcode == BR_BX) begin
				o.next_pc = t.operand_a;
			end else if (t.opcode == BR_BL) begin
				o.link_value = t.seq_pc + 1;
				o.link_write = 1'b1;
				o.next_pc = t.instr_address + 32'(t.pc_offset);
			end else begin
				case (t.opcode)
					BR_B:   take = 1'b1;
					BR_BEQ: take = z;
					BR_BNE: take = !z;
					BR_BLT: take = n;
					BR_BLE: take = n || z;
					BR_BGT: take = !n && !z;
					BR_BGE: take = !n || z;
					default: take = 1'b0;
				endcase
				o.next_pc = take ? t.instr_address + 32'(t.pc_offset) : t.seq_pc;
			end
			o.squash = o.next_pc != t.instr_address + 1;
		end
		o.flags = model_flags;
		return o;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'd0;
			4: return 32'($urandom_range(0, 40)) - 32'd20;
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_t random_instr();
		instr_t t;
		t.action = $urandom_range(0, 9) == 0 ? ACT_W'(3) : ACT_W'($urandom_range(0, 2));
		t.opcode = $urandom_range(0, 4) == 0 ? OP_W'($urandom) :
			OP_W'($urandom_range(0, (t.action == ACT_ALU) ? 31 : 8));
		if (t.action == ACT_ALU && $urandom_range(0, 3) == 0)
			t.opcode = $urandom_range(0, 1) ? OP_CMP : OP_CMPI;
		t.operand_a = pick_operand();
		t.operand_b = pick_operand();
		t.immediate = IMM_W'($urandom);
		t.instr_address = $urandom;
		t.pc_offset = OFF_W'($urandom);
		t.seq_pc = $urandom_range(0, 1) ? t.instr_address + 1 : $urandom;
		return t;
	endfunction

	function automatic instr_t make_instr(logic [1:0] act, logic [4:0] op,
		logic [31:0] a, logic [31:0] b);
		instr_t t;
		t = random_instr();
		t.action = act;
		t.opcode = op;
		t.operand_a = a;
		t.operand_b = b;
		return t;
	endfunction

	// Driver: offers the head of the queue, idling at random between transfers.
	always @(posedge clk or negedge arst_n) begin
		instr_t t;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.action <= '0;
			in_ch.opcode <= '0;
			in_ch.operand_a <= '0;
			in_ch.operand_b <= '0;
			in_ch.immediate <= '0;
			in_ch.instr_address <= '0;
			in_ch.pc_offset <= '0;
			in_ch.seq_pc <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid)
				void'(pending_instrs.pop_front());
			if (pending_instrs.size() != 0 &&
				$urandom_range(1, 100) > send_idle_pct) begin
				t = pending_instrs[0];
				in_ch.valid <= 1'b1;
				in_ch.action <= t.action;
				in_ch.opcode <= t.opcode;
				in_ch.operand_a <= t.operand_a;
				in_ch.operand_b <= t.operand_b;
				in_ch.immediate <= t.immediate;
				in_ch.instr_address <= t.instr_address;
				in_ch.pc_offset <= t.pc_offset;
				in_ch.seq_pc <= t.seq_pc;
				expected_outs = {expected_outs, execute_instr(t)};
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver: stalls at random or for a long hold-off, checks each transfer.
	always @(posedge clk or negedge arst_n) begin
		exec_out_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_outs.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					e = expected_outs.pop_front();
					if (out_ch.result !== e.result) begin
						$error("result: expected %h, got %h", e.result, out_ch.result);
						errors++;
					end
					if (out_ch.flags !== e.flags) begin
						$error("flags: expected %h, got %h", e.flags, out_ch.flags);
						errors++;
					end
					if (out_ch.next_pc !== e.next_pc) begin
						$error("next_pc: expected %h, got %h", e.next_pc, out_ch.next_pc);
						errors++;
					end
					if (out_ch.squash !== e.squash) begin
						$error("squash: expected %b, got %b", e.squash, out_ch.squash);
						errors++;
					end
					if (out_ch.link_value !== e.link_value) begin
						$error("link_value: expected %h, got %h", e.link_value,
							out_ch.link_value);
						errors++;
					end
					if (out_ch.link_write !== e.link_write) begin
						$error("link_write: expected %b, got %b", e.link_write,
							out_ch.link_write);
						errors++;
					end
				end
			end
			if (hold_off_cycles != 0) begin
				hold_off_cycles--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= $urandom_range(1, 100) > recv_stall_pct;
			end
		end
	end

	// Watchdog: counts cycles without any transfer.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else if (arst_n && (pending_instrs.size() != 0 || expected_outs.size() != 0))
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic run_phase(int unsigned n, int unsigned idle, int unsigned stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) add_pending(random_instr());
		wait (pending_instrs.size() == 0 && !in_ch.valid);
	endtask

	initial begin
		logic [4:0] op;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		// Directed part: every even ALU opcode code on extreme operands, divide corner
		// cases, compares feeding the BEQ and BLT branches, BL, BX, and the misc and odd classes.
		for (int i = 0; i < 32; i += 2) begin
			op = OP_W'(i);
			add_pending(make_instr(ACT_ALU, op, 32'h8000_0000,
				(i % 4 == 0) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF));
		end
		add_pending(make_instr(ACT_ALU, OP_DIV, 32'd7, 32'd0));
		add_pending(make_instr(ACT_ALU, OP_MODI, 32'hFFFF_FFF9, 32'd0));
		add_pending(make_instr(ACT_ALU, OP_CMP, 32'd5, 32'd5));
		add_pending(make_instr(ACT_BRANCH, BR_BEQ, 32'd0, 32'd0));
		add_pending(make_instr(ACT_ALU, OP_CMPI, 32'h8000_0000, 32'd1));
		add_pending(make_instr(ACT_BRANCH, BR_BLT, 32'd0, 32'd0));
		add_pending(make_instr(ACT_BRANCH, BR_BL, 32'd0, 32'd0));
		add_pending(make_instr(ACT_BRANCH, BR_BX, 32'hFFFF_FFFF, 32'd0));
		add_pending(make_instr(ACT_MISC, MS_LDI, 32'd0, 32'd0));
		add_pending(make_instr(ACT_W'(3), OP_CMPI, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		wait (pending_instrs.size() == 0 && !in_ch.valid);
		run_phase(130, 0, 0);
		run_phase(110, 70, 0);
		run_phase(110, 0, 70);
		// The receiver holds off for a long stretch while items keep coming.
		hold_off_cycles = 300;
		run_phase(40, 0, 0);
		run_phase(110, 22, 22);
		wait (expected_outs.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
src/abeu_pkg.sv
src/abeu_in_if.sv
src/abeu_out_if.sv
src/abeu_ctrl.sv
src/abeu_dp.sv
src/alu_branch_execute_unit.sv
dv/abeu_tb_pkg.sv
dv/abeu_tb_ifs.sv
dv/alu_branch_execute_unit_tb.sv
